// File: hw/rtl/tlblru_pkg.sv
// Package for the four-entry fully associative TLB with LRU replacement.
// Holds field widths, configuration register indexes, reset values and the
// lookup result type shared by the core and the top level. No dependencies.
package tlblru_pkg;

   // Default sizes handed to the top-level parameters.
   localparam int ENTRIES_DEF   = 4;
   localparam int TIME_BITS_DEF = 32;

   // Fixed field widths.
   localparam int VA_W       = 16;
   localparam int PAGE_W     = 4;
   localparam int OFFSET_W   = 12;
   localparam int FRAME_W    = 2;
   localparam int PA_W       = 14;
   localparam int MISS_W     = 16;
   localparam int ENTRY_ID_W = 2;

   localparam logic [MISS_W-1:0] MISS_MAX = '1;

   // Configuration port.
   localparam int FRAME_REGS  = 4;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_ENTRY0 = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_ENTRY1 = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_ENTRY2 = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_ENTRY3 = 4'd3;

   localparam logic [FRAME_W-1:0] FRAME_ENTRY0_RESET = 2'd2;
   localparam logic [FRAME_W-1:0] FRAME_ENTRY1_RESET = 2'd3;
   localparam logic [FRAME_W-1:0] FRAME_ENTRY2_RESET = 2'd0;
   localparam logic [FRAME_W-1:0] FRAME_ENTRY3_RESET = 2'd1;

   // Outcome of one lookup, passed from the core to the result register.
   typedef struct packed {
      logic                  hit;
      logic [ENTRY_ID_W-1:0] entry;
      logic [MISS_W-1:0]     miss_total;
   } tlblru_result_type;

endpackage

// File: hw/rtl/tlblru_victim.sv
// Replacement victim selection for the TLB: lowest invalid entry, else the
// entry with the smallest timestamp, lowest index on a tie.
// Depends on tlblru_pkg only for the parameter defaults.
module tlblru_victim #(
   parameter int ENTRIES   = tlblru_pkg::ENTRIES_DEF,
   parameter int TIME_BITS = tlblru_pkg::TIME_BITS_DEF,
   localparam int SLOT_W   = $clog2(ENTRIES)
) (
   input  logic [ENTRIES-1:0]   entry_valid,
   input  logic [TIME_BITS-1:0] entry_stamp [ENTRIES],
   output logic [SLOT_W-1:0]    victim
);

   import tlblru_pkg::*;

   localparam int LEAVES = 1 << SLOT_W;
   localparam int NODES  = 2 * LEAVES - 1;
   localparam int KEY_W  = TIME_BITS + 2;

   // Key layout: {absent, valid, stamp}. Invalid entries get key zero so that
   // they win over every valid one; padding leaves never win.
   logic [KEY_W-1:0]  leaf_key [LEAVES];
   logic [KEY_W-1:0]  node_key [NODES];
   logic [SLOT_W-1:0] node_idx [NODES];

   for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
      if (i < ENTRIES) begin : g_real
         assign leaf_key[i] = entry_valid[i] ? {2'b01, entry_stamp[i]} : '0;
      end else begin : g_pad
         assign leaf_key[i] = {2'b10, {TIME_BITS{1'b0}}};
      end
   end

   // Binary tournament tree in heap order; the left child wins ties, which
   // keeps the lowest index.
   always_comb begin
      for (int i = 0; i < LEAVES; i++) begin
         node_key[LEAVES - 1 + i] = leaf_key[i];
         node_idx[LEAVES - 1 + i] = SLOT_W'(i);
      end
      for (int j = LEAVES - 2; j >= 0; j--) begin
         if (node_key[2 * j + 1] <= node_key[2 * j + 2]) begin
            node_key[j] = node_key[2 * j + 1];
            node_idx[j] = node_idx[2 * j + 1];
         end else begin
            node_key[j] = node_key[2 * j + 2];
            node_idx[j] = node_idx[2 * j + 2];
         end
      end
   end

   assign victim = node_idx[0];

endmodule

// File: hw/rtl/tlblru_core.sv
// TLB entry state and lookup: tag compare, victim choice, stamp and counter
// update. Depends on tlblru_pkg and tlblru_victim.
module tlblru_core #(
   parameter int ENTRIES   = tlblru_pkg::ENTRIES_DEF,
   parameter int TIME_BITS = tlblru_pkg::TIME_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           lookup_valid,
   input  logic [tlblru_pkg::PAGE_W-1:0]  lookup_page,
   output tlblru_pkg::tlblru_result_type  result
);

   import tlblru_pkg::*;

   localparam int SLOT_W = $clog2(ENTRIES);

   logic [PAGE_W-1:0]    tag_ff   [ENTRIES];
   logic [TIME_BITS-1:0] stamp_ff [ENTRIES];
   logic [ENTRIES-1:0]   valid_ff;
   logic [TIME_BITS-1:0] time_ff;
   logic [MISS_W-1:0]    miss_ff;

   logic [TIME_BITS-1:0] time_in;
   logic [MISS_W-1:0]    miss_in;
   logic [ENTRIES-1:0]   match;
   logic                 hit;
   logic [SLOT_W-1:0]    hit_slot;
   logic [SLOT_W-1:0]    victim;
   logic [SLOT_W-1:0]    slot;

   tlblru_victim #(
      .ENTRIES   (ENTRIES),
      .TIME_BITS (TIME_BITS)
   ) u_victim (
      .entry_valid (valid_ff),
      .entry_stamp (stamp_ff),
      .victim      (victim)
   );

   always_comb begin
      for (int k = 0; k < ENTRIES; k++) begin
         match[k] = valid_ff[k] && (tag_ff[k] == lookup_page);
      end
      hit      = |match;
      hit_slot = '0;
      for (int k = ENTRIES - 1; k >= 0; k--) begin
         if (match[k]) begin
            hit_slot = SLOT_W'(k);
         end
      end
      slot    = hit ? hit_slot : victim;
      time_in = time_ff + (hit ? TIME_BITS'(1) : TIME_BITS'(2));
      miss_in = (!hit && (miss_ff != MISS_MAX)) ? miss_ff + MISS_W'(1) : miss_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         time_ff  <= '0;
         miss_ff  <= '0;
      end else if (lookup_valid) begin
         valid_ff[slot] <= 1'b1;
         time_ff        <= time_in;
         miss_ff        <= miss_in;
      end
   end

   // Tags and stamps are only read behind a valid bit.
   always_ff @(posedge clock) begin
      if (lookup_valid) begin
         tag_ff[slot]   <= lookup_page;
         stamp_ff[slot] <= time_in;
      end
   end

   assign result.hit        = hit;
   assign result.entry      = ENTRY_ID_W'(slot);
   assign result.miss_total = miss_in;

endmodule

// File: hw/rtl/tlb_lookup_lru_replace_top.sv
// Top level of the fully associative TLB with LRU replacement: command
// register, frame configuration registers and result register.
// Depends on tlblru_pkg and tlblru_core.
//
//   Channel   Ports                                   Transfer when
//   -------   -------------------------------------   -----------------------
//   request   start, busy, req_virtual_address        start && !busy
//   response  rsp_valid, rsp_hit .. rsp_miss_total    rsp_valid (one cycle)
//   config    csr_valid, csr_ready, csr_index/data    csr_valid && csr_ready
//
// One translation is accepted every cycle; busy stays low. A request
// registered in the command register is looked up in the following cycle,
// and its result is captured by the result register and appears on the
// response ports for exactly one cycle. The single lookup stage between the
// command register and the result register sets the rate.
// Synchronous active-high reset clears all entries, the time and miss
// counters and restores the frame registers; the receiver cannot stall.
module tlb_lookup_lru_replace_top #(
   parameter int ENTRIES   = tlblru_pkg::ENTRIES_DEF,
   parameter int TIME_BITS = tlblru_pkg::TIME_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                start,
   output logic                                busy,
   input  logic [tlblru_pkg::VA_W-1:0]         req_virtual_address,
   // Response channel.
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic [tlblru_pkg::PAGE_W-1:0]       rsp_page_number,
   output logic [tlblru_pkg::OFFSET_W-1:0]     rsp_page_offset,
   output logic [tlblru_pkg::ENTRY_ID_W-1:0]   rsp_entry_used,
   output logic [tlblru_pkg::FRAME_W-1:0]      rsp_frame_number,
   output logic [tlblru_pkg::PA_W-1:0]         rsp_physical_address,
   output logic [tlblru_pkg::MISS_W-1:0]       rsp_miss_total,
   // Configuration channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tlblru_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tlblru_pkg::CSR_DATA_W-1:0]   csr_data
);

   import tlblru_pkg::*;

   // The pipeline never holds off a request or a configuration write.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   logic                req_accept;
   logic                in_valid_ff;
   logic [VA_W-1:0]     va_ff;
   logic [FRAME_W-1:0]  frame_ff [FRAME_REGS];

   tlblru_result_type   lookup;
   logic [FRAME_W-1:0]  frame_in;

   logic                    rsp_valid_ff;
   logic                    rsp_hit_ff;
   logic [PAGE_W-1:0]       rsp_page_ff;
   logic [OFFSET_W-1:0]     rsp_offset_ff;
   logic [ENTRY_ID_W-1:0]   rsp_entry_ff;
   logic [FRAME_W-1:0]      rsp_frame_ff;
   logic [MISS_W-1:0]       rsp_miss_ff;

   assign req_accept = start && !busy;

   // Command register: the virtual address waits here while the core reads
   // and updates its entries.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         va_ff <= req_virtual_address;
      end
   end

   // Frame registers. Writes to indexes past the last register are dropped,
   // and only the low bits of the data are kept.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff[0] <= FRAME_ENTRY0_RESET;
         frame_ff[1] <= FRAME_ENTRY1_RESET;
         frame_ff[2] <= FRAME_ENTRY2_RESET;
         frame_ff[3] <= FRAME_ENTRY3_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_ENTRY0: frame_ff[0] <= csr_data[FRAME_W-1:0];
            CSR_FRAME_ENTRY1: frame_ff[1] <= csr_data[FRAME_W-1:0];
            CSR_FRAME_ENTRY2: frame_ff[2] <= csr_data[FRAME_W-1:0];
            CSR_FRAME_ENTRY3: frame_ff[3] <= csr_data[FRAME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   tlblru_core #(
      .ENTRIES   (ENTRIES),
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .lookup_valid (in_valid_ff),
      .lookup_page  (va_ff[VA_W-1 -: PAGE_W]),
      .result       (lookup)
   );

   // With more than four entries, entry i shares frame register i mod 4; the
   // core already reports the low two bits of the entry index.
   assign frame_in = frame_ff[lookup.entry];

   // Result register: rsp_valid marks each translation for exactly one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff) begin
         rsp_hit_ff    <= lookup.hit;
         rsp_page_ff   <= va_ff[VA_W-1 -: PAGE_W];
         rsp_offset_ff <= va_ff[OFFSET_W-1:0];
         rsp_entry_ff  <= lookup.entry;
         rsp_frame_ff  <= frame_in;
         rsp_miss_ff   <= lookup.miss_total;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_page_number      = rsp_page_ff;
   assign rsp_page_offset      = rsp_offset_ff;
   assign rsp_entry_used       = rsp_entry_ff;
   assign rsp_frame_number     = rsp_frame_ff;
   assign rsp_physical_address = {rsp_frame_ff, rsp_offset_ff};
   assign rsp_miss_total       = rsp_miss_ff;

   // Every accepted request produces its result after the command and result registers.
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> ##1 rsp_valid)
      else $error("accepted request did not produce a result");

   // A miss always leaves a nonzero miss count, saturation included.
   a_miss_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_miss_total != '0))
      else $error("miss reported with zero miss count");

   // Back-to-back results: a hit leaves the miss count unchanged.
   a_hit_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit && $past(rsp_valid)) |->
         (rsp_miss_total == $past(rsp_miss_total)))
      else $error("miss count changed on a hit");

endmodule

// File: dv/tb_tlb_lookup_lru_replace_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the four-entry fully associative TLB with LRU
// replacement: a queue-fed driver, a scoreboard monitor and a cycle-accurate
// TLB predictor. Depends only on tlblru_pkg and tlb_lookup_lru_replace_top.
module tb_tlb_lookup_lru_replace_top;
   import tlblru_pkg::*;

   localparam int LINES         = ENTRIES_DEF;
   localparam int STAMP_W       = TIME_BITS_DEF;
   localparam int FRAME_SEL_W   = $clog2(FRAME_REGS);
   localparam int RESET_CYCLES  = 4;
   localparam int SETTLE_CYCLES = 4;
   localparam int STALL_LIMIT   = 1000;
   localparam int MAX_GAP       = 4;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 120;
   // Back-to-back lookups that rotate more pages than the TLB holds.
   localparam int THRASH_ITEMS  = 80;

   // One expected translation, field for field as the response ports show it.
   typedef struct packed {
      logic                  hit;
      logic [PAGE_W-1:0]     page;
      logic [OFFSET_W-1:0]   offset;
      logic [ENTRY_ID_W-1:0] entry;
      logic [FRAME_W-1:0]    frame;
      logic [PA_W-1:0]       paddr;
      logic [MISS_W-1:0]     misses;
   } translation_type;

   // Every input of the block starts at a known value.
   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   start     = 1'b0;
   logic [VA_W-1:0]        req_virtual_address = '0;
   logic                   csr_valid = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   logic                   busy;
   logic                   rsp_valid;
   logic                   rsp_hit;
   logic [PAGE_W-1:0]      rsp_page_number;
   logic [OFFSET_W-1:0]    rsp_page_offset;
   logic [ENTRY_ID_W-1:0]  rsp_entry_used;
   logic [FRAME_W-1:0]     rsp_frame_number;
   logic [PA_W-1:0]        rsp_physical_address;
   logic [MISS_W-1:0]      rsp_miss_total;
   logic                   csr_ready;

   // Addresses waiting to be sent, and translations waiting to come back.
   logic [VA_W-1:0]        pending_addresses[$];
   translation_type        expected_translations[$];

   // Predictor copy of the TLB contents and of the frame registers.
   logic [PAGE_W-1:0]      tag_of[LINES];
   logic                   valid_of[LINES];
   logic [STAMP_W-1:0]     stamp_of[LINES];
   logic [STAMP_W-1:0]     now_stamp;
   logic [MISS_W-1:0]      misses_seen;
   logic [FRAME_W-1:0]     frame_cfg[FRAME_REGS];

   // When set, the driver sends items back to back with no idle cycles.
   bit                     burst_mode = 1'b0;
   int                     mismatches = 0;
   int                     stall_cycles = 0;

   tlb_lookup_lru_replace_top i_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_virtual_address  (req_virtual_address),
      .rsp_valid            (rsp_valid),
      .rsp_hit              (rsp_hit),
      .rsp_page_number      (rsp_page_number),
      .rsp_page_offset      (rsp_page_offset),
      .rsp_entry_used       (rsp_entry_used),
      .rsp_frame_number     (rsp_frame_number),
      .rsp_physical_address (rsp_physical_address),
      .rsp_miss_total       (rsp_miss_total),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   // The clock runs with a period of 8 ns.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Puts the predictor into its post-reset state.
   function automatic void reset_tlb_model();
      int k;
      for (k = 0; k < LINES; k++) begin
         tag_of[k]   = '0;
         valid_of[k] = 1'b0;
         stamp_of[k] = '0;
      end
      now_stamp    = '0;
      misses_seen  = '0;
      frame_cfg[0] = FRAME_ENTRY0_RESET;
      frame_cfg[1] = FRAME_ENTRY1_RESET;
      frame_cfg[2] = FRAME_ENTRY2_RESET;
      frame_cfg[3] = FRAME_ENTRY3_RESET;
   endfunction

   // Looks one address up in the predictor, updates its state and returns
   // the translation that the block must report for it.
   function automatic translation_type translate_address(input logic [VA_W-1:0] va);
      translation_type    res;
      logic [PAGE_W-1:0]  page;
      logic               found;
      logic               have_free;
      logic [STAMP_W-1:0] oldest;
      int                 slot;
      int                 k;
      page  = va[VA_W-1 -: PAGE_W];
      found = 1'b0;
      slot  = 0;
      for (k = 0; k < LINES; k++) begin
         if (!found && valid_of[k] && tag_of[k] == page) begin
            found = 1'b1;
            slot  = k;
         end
      end
      now_stamp = now_stamp + 1'b1;
      if (!found) begin
         // A miss costs one more tick and replaces a victim: the first empty
         // entry, otherwise the oldest stamp with the lower index on a tie.
         now_stamp = now_stamp + 1'b1;
         if (misses_seen != MISS_MAX) begin
            misses_seen = misses_seen + 1'b1;
         end
         have_free = 1'b0;
         oldest    = stamp_of[0];
         for (k = 0; k < LINES; k++) begin
            if (!have_free) begin
               if (!valid_of[k]) begin
                  have_free = 1'b1;
                  slot      = k;
               end else if (stamp_of[k] < oldest) begin
                  oldest = stamp_of[k];
                  slot   = k;
               end
            end
         end
         tag_of[slot]   = page;
         valid_of[slot] = 1'b1;
      end
      stamp_of[slot] = now_stamp;
      res.hit    = found;
      res.page   = page;
      res.offset = va[OFFSET_W-1:0];
      res.entry  = ENTRY_ID_W'(slot);
      res.frame  = frame_cfg[res.entry];
      res.paddr  = {res.frame, res.offset};
      res.misses = misses_seen;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, want);
   endtask

   // Request driver. An item is transferred at an edge where start is high
   // and busy is low; its translation is predicted at that same edge. Unless
   // burst mode is set, each transfer is followed by a randomly drawn idle gap.
   always @(posedge clock) begin
      int gap_left;
      if (reset) begin
         start    <= 1'b0;
         gap_left = 0;
         reset_tlb_model();
      end else begin
         if (start && !busy) begin
            expected_translations.push_back(translate_address(req_virtual_address));
         end
         if (start && busy) begin
            // The item is held until the block takes it.
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_addresses.size() != 0) begin
            req_virtual_address <= pending_addresses.pop_front();
            start               <= 1'b1;
            gap_left            = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor. It applies frame register transfers to the predictor and checks
   // each response against the oldest predicted translation.
   always @(posedge clock) begin
      translation_type want;
      if (!reset) begin
         if (csr_valid && csr_ready && csr_index < FRAME_REGS) begin
            frame_cfg[csr_index[FRAME_SEL_W-1:0]] = csr_data[FRAME_W-1:0];
         end
         if (rsp_valid) begin
            if (expected_translations.size() == 0) begin
               report_mismatch("response with no translation outstanding",
                               32'({rsp_page_number, rsp_page_offset}), 32'd0);
            end else begin
               want = expected_translations.pop_front();
               if (rsp_hit !== want.hit)
                  report_mismatch("hit", 32'(rsp_hit), 32'(want.hit));
               if (rsp_page_number !== want.page)
                  report_mismatch("page_number", 32'(rsp_page_number), 32'(want.page));
               if (rsp_page_offset !== want.offset)
                  report_mismatch("page_offset", 32'(rsp_page_offset), 32'(want.offset));
               if (rsp_entry_used !== want.entry)
                  report_mismatch("entry_used", 32'(rsp_entry_used), 32'(want.entry));
               if (rsp_frame_number !== want.frame)
                  report_mismatch("frame_number", 32'(rsp_frame_number), 32'(want.frame));
               if (rsp_physical_address !== want.paddr)
                  report_mismatch("physical_address", 32'(rsp_physical_address),
                                  32'(want.paddr));
               if (rsp_miss_total !== want.misses)
                  report_mismatch("miss_total", 32'(rsp_miss_total), 32'(want.misses));
            end
         end
      end
   end

   // Watchdog. Any transfer on any channel restarts the count; a long
   // stretch without one means the block has hung.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Writes one configuration register and waits for the transfer.
   task automatic write_frame_reg(input logic [CSR_INDEX_W-1:0] idx,
                                  input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Waits until every queued address has been sent and every predicted
   // translation has come back, then lets the pipeline settle.
   task automatic wait_idle();
      @(posedge clock);
      while (pending_addresses.size() != 0 || start || expected_translations.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One random phase: fresh frame registers, then addresses drawn mostly
   // from a small pool of pages so that hits, refills and LRU evictions all
   // occur. A pool larger than the TLB makes it thrash.
   task automatic run_random_phase(input int count);
      logic [PAGE_W-1:0] pool[8];
      int                pool_size;
      int                r;
      int                n;
      for (r = 0; r < FRAME_REGS; r++) begin
         write_frame_reg(CSR_FRAME_ENTRY0 + CSR_INDEX_W'(r), CSR_DATA_W'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1) == 1) begin
         // Writes above the last register index must leave the frames alone.
         write_frame_reg(CSR_INDEX_W'($urandom_range(FRAME_REGS, 2**CSR_INDEX_W - 1)),
                         CSR_DATA_W'($urandom_range(0, 255)));
      end
      burst_mode = ($urandom_range(0, 3) == 0);
      pool_size  = $urandom_range(2, 8);
      for (r = 0; r < pool_size; r++) begin
         pool[r] = PAGE_W'($urandom_range(0, 2**PAGE_W - 1));
      end
      for (n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0) begin
            pending_addresses.push_back(VA_W'($urandom_range(0, 2**VA_W - 1)));
         end else begin
            pending_addresses.push_back({pool[$urandom_range(0, pool_size - 1)],
                                         OFFSET_W'($urandom_range(0, 2**OFFSET_W - 1))});
         end
      end
      wait_idle();
   endtask

   // Test sequence.
   initial begin
      logic [PAGE_W-1:0] base_page;
      int                r;
      int                n;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      // Directed lookups under the reset frame values: address extremes, a
      // cold fill of every entry, hits that refresh stamps, and misses that
      // evict the least recently used entry once the TLB is full.
      pending_addresses.push_back(16'h0000);
      pending_addresses.push_back(16'h0FFF);
      pending_addresses.push_back(16'hFFFF);
      pending_addresses.push_back(16'hF000);
      pending_addresses.push_back(16'h1ABC);
      pending_addresses.push_back(16'h2555);
      pending_addresses.push_back(16'h0123);
      pending_addresses.push_back(16'h3AAA);
      pending_addresses.push_back(16'hF001);
      pending_addresses.push_back(16'h3555);
      pending_addresses.push_back(16'h5A5A);
      pending_addresses.push_back(16'h0800);
      pending_addresses.push_back(16'h1001);
      wait_idle();

      // All frames at zero, written with the upper data bits set, plus a
      // write to the highest index, which the block has to ignore.
      for (r = 0; r < FRAME_REGS; r++) begin
         write_frame_reg(CSR_FRAME_ENTRY0 + CSR_INDEX_W'(r), 8'hFC);
      end
      write_frame_reg('1, 8'hFF);
      pending_addresses.push_back(16'h0FFF);
      pending_addresses.push_back(16'h5000);
      pending_addresses.push_back(16'h3FFF);
      pending_addresses.push_back(16'h1FFF);
      pending_addresses.push_back(16'h7777);
      wait_idle();

      // All frames at three.
      for (r = 0; r < FRAME_REGS; r++) begin
         write_frame_reg(CSR_FRAME_ENTRY0 + CSR_INDEX_W'(r), (r % 2 == 0) ? 8'h03 : 8'hFF);
      end
      write_frame_reg(CSR_INDEX_W'(FRAME_REGS), 8'h00);
      pending_addresses.push_back(16'h7FFF);
      pending_addresses.push_back(16'h0000);
      pending_addresses.push_back(16'h5001);
      pending_addresses.push_back(16'h3000);
      pending_addresses.push_back(16'hE000);
      pending_addresses.push_back(16'hEFFF);
      wait_idle();

      for (n = 0; n < RANDOM_PHASES; n++) begin
         run_random_phase(PHASE_ITEMS);
      end

      // Five pages in rotation through four LRU entries miss on almost every
      // lookup once the rotation is under way; they are sent back to back.
      burst_mode = 1'b1;
      base_page  = PAGE_W'($urandom_range(0, 2**PAGE_W - 1));
      for (n = 0; n < THRASH_ITEMS; n++) begin
         pending_addresses.push_back({PAGE_W'(base_page + n % 5),
                                      OFFSET_W'($urandom_range(0, 2**OFFSET_W - 1))});
      end
      wait_idle();

      // Normal traffic after the thrashing run.
      run_random_phase(40);

      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
